// File: rtl/v3fa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package v3fa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  // one root bit per cell, 32-bit root of a 64-bit radicand
  localparam int unsigned SQRT_STEPS    = 32;

  localparam logic [3:0] ACT_ADDV  = 4'd0;
  localparam logic [3:0] ACT_ADDS  = 4'd1;
  localparam logic [3:0] ACT_SUBV  = 4'd2;
  localparam logic [3:0] ACT_SUBS  = 4'd3;
  localparam logic [3:0] ACT_MULV  = 4'd4;
  localparam logic [3:0] ACT_MULS  = 4'd5;
  localparam logic [3:0] ACT_DIVV  = 4'd6;
  localparam logic [3:0] ACT_DIVS  = 4'd7;
  localparam logic [3:0] ACT_NEG   = 4'd8;
  localparam logic [3:0] ACT_EQ    = 4'd9;
  localparam logic [3:0] ACT_DOT   = 4'd10;
  localparam logic [3:0] ACT_CROSS = 4'd11;
  localparam logic [3:0] ACT_LEN   = 4'd12;
  localparam logic [3:0] ACT_NORM  = 4'd13;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_in;
    logic               b_two_d;
  } req_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               equal_flag;
    logic               overflow;
  } rsp_t;

  // side data that rides along the root and divide cells
  typedef struct packed {
    logic [3:0]       act;
    logic [2:0][31:0] r_pre;
    logic [31:0]      sc_pre;
    logic             eqf;
    logic             ov;
    logic [2:0]       use_div;
    logic [2:0]       neg;
    logic [2:0]       dz;
    logic [2:0][31:0] num;
    logic [2:0][31:0] den;
  } ctx_t;

  function automatic logic signed [65:0] sx32(input logic [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [65:0] sx64(input logic [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  // {overflow, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // product shifted down, truncated toward zero
  function automatic logic [63:0] trunc_q(input logic [63:0] p, input int unsigned f);
    logic [63:0] m;
    logic [63:0] q;
    m = p[63] ? (64'd0 - p) : p;
    q = m >> f;
    return p[63] ? (64'd0 - q) : q;
  endfunction

endpackage

`default_nettype wire

// File: rtl/v3fa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module v3fa_front #(
  parameter int unsigned FRAC_BITS = v3fa_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  v3fa_pkg::req_t  in_item,
  output logic            out_valid,
  output v3fa_pkg::ctx_t  out_ctx,
  output logic [63:0]     out_rad
);
  import v3fa_pkg::*;

  logic [5:0][31:0] mx;
  logic [5:0][31:0] my;
  logic [2:0][31:0] av;
  logic [2:0][31:0] bv;

  logic             s1_valid;
  req_t             s1_item;
  logic [5:0][63:0] s1_p;
  logic             s2_valid;
  req_t             s2_item;
  logic [5:0][63:0] s2_t;
  logic [63:0]      s2_sq;

  logic [2:0][31:0] a3;
  logic [2:0][31:0] b3;
  ctx_t             ctx_next;
  logic             lane_on;
  logic             ovl;
  logic [32:0]      sv;
  logic [31:0]      dsrc;
  logic signed [65:0] ae;
  logic signed [65:0] be;
  logic signed [65:0] se;
  logic signed [65:0] te;

  // operand select for the six multipliers
  always_comb begin
    av = {in_item.az, in_item.ay, in_item.ax};
    bv = {(in_item.b_two_d ? 32'd0 : in_item.bz), in_item.by, in_item.bx};
    for (int i = 0; i < 3; i++) begin
      mx[i]   = av[i];
      my[i]   = bv[i];
      mx[i+3] = av[i];
      my[i+3] = bv[i];
    end
    case (in_item.action) inside
      ACT_MULS: begin
        for (int i = 0; i < 3; i++) my[i] = in_item.scalar_in;
      end
      ACT_LEN, ACT_NORM: begin
        for (int i = 0; i < 3; i++) my[i] = av[i];
      end
      ACT_CROSS: begin
        mx[0] = av[1]; my[0] = bv[2];
        mx[1] = av[2]; my[1] = bv[0];
        mx[2] = av[0]; my[2] = bv[1];
        mx[3] = av[2]; my[3] = bv[1];
        mx[4] = av[0]; my[4] = bv[2];
        mx[5] = av[1]; my[5] = bv[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item <= in_item;
      for (int j = 0; j < 6; j++) s1_p[j] <= $signed(mx[j]) * $signed(my[j]);
      s2_item <= s1_item;
      for (int j = 0; j < 6; j++) s2_t[j] <= trunc_q(s1_p[j], FRAC_BITS);
      s2_sq   <= s1_p[0] + s1_p[1] + s1_p[2];
      out_ctx <= ctx_next;
      out_rad <= s2_sq;
    end
  end

  // everything but the divides and the root is settled here
  always_comb begin
    a3 = {s2_item.az, s2_item.ay, s2_item.ax};
    b3 = {(s2_item.b_two_d ? 32'd0 : s2_item.bz), s2_item.by, s2_item.bx};
    se = sx32(s2_item.scalar_in);
    ctx_next = '0;
    ctx_next.act = s2_item.action;
    lane_on = 1'b1;
    ovl = 1'b0;
    sv = '0;
    dsrc = '0;
    ae = '0;
    be = '0;
    te = '0;
    for (int i = 0; i < 3; i++) begin
      lane_on = !(s2_item.b_two_d && (i == 2));
      ae = sx32(a3[i]);
      be = sx32(b3[i]);
      te = sx64(s2_t[i]);
      case (s2_item.action) inside
        ACT_ADDV:          sv = sat32(ae + be);
        ACT_ADDS:          sv = sat32(ae + se);
        ACT_SUBV:          sv = sat32(ae - be);
        ACT_SUBS:          sv = sat32(ae - se);
        ACT_MULV, ACT_MULS: sv = sat32(te);
        ACT_NEG:           sv = sat32(66'sd0 - ae);
        ACT_CROSS:         sv = sat32(te - sx64(s2_t[i+3]));
        default:           sv = '0;
      endcase
      ctx_next.r_pre[i] = sv[31:0];
      ovl = sv[32];
      if (!lane_on && (s2_item.action == ACT_ADDV || s2_item.action == ACT_SUBV ||
                       s2_item.action == ACT_MULV || s2_item.action == ACT_DIVV)) begin
        ctx_next.r_pre[i] = a3[i];
        ovl = 1'b0;
      end
      ctx_next.ov = ctx_next.ov | ovl;

      dsrc = (s2_item.action == ACT_DIVS) ? s2_item.scalar_in : b3[i];
      ctx_next.num[i] = a3[i][31] ? (32'd0 - a3[i]) : a3[i];
      ctx_next.den[i] = dsrc[31] ? (32'd0 - dsrc) : dsrc;
      ctx_next.dz[i]  = (dsrc == 32'd0);
      ctx_next.neg[i] = a3[i][31] ^ dsrc[31];
      case (s2_item.action) inside
        ACT_DIVV: ctx_next.use_div[i] = lane_on;
        ACT_DIVS: ctx_next.use_div[i] = 1'b1;
        ACT_NORM: begin
          ctx_next.use_div[i] = 1'b1;
          ctx_next.neg[i]     = a3[i][31];
        end
        default:  ctx_next.use_div[i] = 1'b0;
      endcase
    end
    if (s2_item.action == ACT_DOT) begin
      sv = sat32(sx64(s2_t[0]) + sx64(s2_t[1]) + sx64(s2_t[2]));
      ctx_next.sc_pre = sv[31:0];
      ctx_next.ov     = sv[32];
    end
    if (s2_item.action == ACT_EQ) begin
      ctx_next.eqf = (a3 == b3);
    end
  end

endmodule

`default_nettype wire

// File: rtl/v3fa_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module v3fa_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  v3fa_pkg::ctx_t in_ctx,
  input  logic [63:0]    in_rad,
  input  logic [33:0]    in_rem,
  input  logic [31:0]    in_root,
  output logic           out_valid,
  output v3fa_pkg::ctx_t out_ctx,
  output logic [63:0]    out_rad,
  output logic [33:0]    out_rem,
  output logic [31:0]    out_root
);
  import v3fa_pkg::*;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  // bring down two radicand bits, try root*4+1
  assign rem_sh = {in_rem, in_rad[63:62]};
  assign trial  = {2'b00, in_root, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx  <= in_ctx;
      out_rad  <= {in_rad[61:0], 2'b00};
      out_rem  <= ge ? diff[33:0] : rem_sh[33:0];
      out_root <= {in_root[30:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/v3fa_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module v3fa_div_cell #(
  parameter int unsigned NW = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  v3fa_pkg::ctx_t         in_ctx,
  input  logic [2:0][31:0]       in_den,
  input  logic [2:0][NW-1:0]     in_num,
  input  logic [2:0][31:0]       in_rem,
  input  logic [2:0][NW-1:0]     in_quo,
  output logic                   out_valid,
  output v3fa_pkg::ctx_t         out_ctx,
  output logic [2:0][31:0]       out_den,
  output logic [2:0][NW-1:0]     out_num,
  output logic [2:0][31:0]       out_rem,
  output logic [2:0][NW-1:0]     out_quo
);
  import v3fa_pkg::*;

  logic [2:0][32:0] rem_sh;
  logic [2:0][32:0] diff;
  logic [2:0]       ge;

  // one restoring step per lane: one quotient bit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {in_rem[i], in_num[i][NW-1]};
      diff[i]   = rem_sh[i] - {1'b0, in_den[i]};
      ge[i]     = (rem_sh[i] >= {1'b0, in_den[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= in_ctx;
      out_den <= in_den;
      for (int i = 0; i < 3; i++) begin
        out_num[i] <= {in_num[i][NW-2:0], 1'b0};
        out_rem[i] <= ge[i] ? diff[i][31:0] : rem_sh[i][31:0];
        out_quo[i] <= {in_quo[i][NW-2:0], ge[i]};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/vector3_fixed_point_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path from the accepting edge to rsp_valid (FRAC_BITS is 16, Q16.16, by default):
//   3 front stages (multiply, truncate, combine), 32 square-root cells, 32+FRAC_BITS divide cells,
//   one output register. Every op takes the same path, so order is kept.
// Throughput: one beat per cycle while the chain advances; every cell hands its work to the next cell on each advance.
// The whole chain advances together and holds only while a result waits under rsp_stall.
// Reset (rst, synchronous): clears all valid bits; no payload is reset.
module vector3_fixed_point_alu_core #(
  parameter int unsigned FRAC_BITS = v3fa_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  v3fa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output v3fa_pkg::rsp_t rsp
);
  import v3fa_pkg::*;

  // quotient bits: dividend magnitude scaled by 2^FRAC_BITS
  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam logic [NW-1:0] LIM_POS = NW'(33'h0_7FFF_FFFF);
  localparam logic [NW-1:0] LIM_NEG = NW'(33'h0_8000_0000);

  // global advance: the chain moves unless a finished beat is held at the output
  logic en;
  assign en        = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  // square-root chain, index 0 fed by the front end
  logic        sq_valid [SQRT_STEPS+1];
  ctx_t        sq_ctx   [SQRT_STEPS+1];
  logic [63:0] sq_rad   [SQRT_STEPS+1];
  logic [33:0] sq_rem   [SQRT_STEPS+1];
  logic [31:0] sq_root  [SQRT_STEPS+1];

  v3fa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .in_item   (req),
    .out_valid (sq_valid[0]),
    .out_ctx   (sq_ctx[0]),
    .out_rad   (sq_rad[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    v3fa_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[k]),
      .in_ctx    (sq_ctx[k]),
      .in_rad    (sq_rad[k]),
      .in_rem    (sq_rem[k]),
      .in_root   (sq_root[k]),
      .out_valid (sq_valid[k+1]),
      .out_ctx   (sq_ctx[k+1]),
      .out_rad   (sq_rad[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_root  (sq_root[k+1])
    );
  end

  // between the chains: length result, and the length becomes the
  // divisor for normalize (a zero length means a zero vector, so 0 out)
  logic [31:0] len;
  ctx_t        mid_ctx;

  assign len = sq_root[SQRT_STEPS];

  always_comb begin
    mid_ctx = sq_ctx[SQRT_STEPS];
    if (mid_ctx.act == ACT_NORM) begin
      for (int i = 0; i < 3; i++) begin
        mid_ctx.den[i] = len;
        mid_ctx.dz[i]  = (len == 32'd0);
      end
    end
    if (mid_ctx.act == ACT_LEN) begin
      mid_ctx.sc_pre = len[31] ? 32'h7FFF_FFFF : len;
      mid_ctx.ov     = len[31];
    end
  end

  // divide chain, three lanes side by side in each cell
  logic                 dv_valid [NW+1];
  ctx_t                 dv_ctx   [NW+1];
  logic [2:0][31:0]     dv_den   [NW+1];
  logic [2:0][NW-1:0]   dv_num   [NW+1];
  logic [2:0][31:0]     dv_rem   [NW+1];
  logic [2:0][NW-1:0]   dv_quo   [NW+1];

  assign dv_valid[0] = sq_valid[SQRT_STEPS];
  assign dv_ctx[0]   = mid_ctx;
  assign dv_den[0]   = mid_ctx.den;
  assign dv_rem[0]   = '0;
  assign dv_quo[0]   = '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num[0][i] = {mid_ctx.num[i], {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    v3fa_div_cell #(
      .NW (NW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[k]),
      .in_ctx    (dv_ctx[k]),
      .in_den    (dv_den[k]),
      .in_num    (dv_num[k]),
      .in_rem    (dv_rem[k]),
      .in_quo    (dv_quo[k]),
      .out_valid (dv_valid[k+1]),
      .out_ctx   (dv_ctx[k+1]),
      .out_den   (dv_den[k+1]),
      .out_num   (dv_num[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_quo   (dv_quo[k+1])
    );
  end

  // final assembly: sign and saturate quotients, merge with precomputed lanes
  ctx_t             fin_ctx;
  logic [2:0][31:0] res;
  logic [NW-1:0]    q;
  logic             ov_div;
  rsp_t             rsp_next;

  always_comb begin
    fin_ctx = dv_ctx[NW];
    ov_div  = 1'b0;
    q       = '0;
    for (int i = 0; i < 3; i++) begin
      q      = dv_quo[NW][i];
      res[i] = fin_ctx.r_pre[i];
      if (fin_ctx.use_div[i]) begin
        if (fin_ctx.dz[i]) begin
          res[i] = 32'd0;
        end else if (fin_ctx.neg[i]) begin
          if (q > LIM_NEG) begin
            res[i] = 32'h8000_0000;
            ov_div = 1'b1;
          end else begin
            res[i] = 32'd0 - q[31:0];
          end
        end else begin
          if (q > LIM_POS) begin
            res[i] = 32'h7FFF_FFFF;
            ov_div = 1'b1;
          end else begin
            res[i] = q[31:0];
          end
        end
      end
    end
    rsp_next.rx         = res[0];
    rsp_next.ry         = res[1];
    rsp_next.rz         = res[2];
    rsp_next.scalar_out = fin_ctx.sc_pre;
    rsp_next.equal_flag = fin_ctx.eqf;
    rsp_next.overflow   = fin_ctx.ov | ov_div;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/v3fa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module v3fa_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input v3fa_pkg::rsp_t rsp
);
  import v3fa_pkg::*;

  // input side holds exactly when a finished beat is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    req_stall == (rsp_valid && rsp_stall))
    else $error("req_stall does not follow held output");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

  // compare results carry nothing else
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.equal_flag |-> !rsp.overflow && rsp.scalar_out == 32'd0 &&
      rsp.rx == 32'd0 && rsp.ry == 32'd0 && rsp.rz == 32'd0)
    else $error("equal beat with other fields set");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("rsp_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("rsp changed while stalled");

endmodule

bind vector3_fixed_point_alu_core v3fa_checker u_v3fa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
